// File: rtl/trimmed_mean_adc_to_millivolts_defines.svh
// Assertion macros used by the trimmed-mean ADC filter RTL.
`ifndef TRIMMED_MEAN_ADC_TO_MILLIVOLTS_DEFINES_SVH
`define TRIMMED_MEAN_ADC_TO_MILLIVOLTS_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define TMAV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define TMAV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TMAV_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define TMAV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/tmav_pkg.sv
// Shared types and constants of the trimmed-mean ADC filter.
package tmav_pkg;

   // Field widths
   localparam int SAMPLE_W = 12;
   localparam int RATIO_W  = 4;
   localparam int MV_W     = 28;
   localparam int DIV_W    = 24;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   // Scaling used when no calibration point is available
   localparam logic [SAMPLE_W-1:0] FALLBACK_MV   = 12'd2200;
   localparam logic [SAMPLE_W-1:0] FALLBACK_CODE = 12'd4095;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] CAL_CODE_RESET = 12'd0;
   localparam logic [SAMPLE_W-1:0] CAL_MV_RESET   = 12'd850;
   localparam logic [RATIO_W-1:0]  RATIO_RESET    = 4'd5;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [1:0] {
      REG_CAL_CODE  = 2'd0,
      REG_CAL_MV    = 2'd1,
      REG_DIV_RATIO = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] cal_code;
      logic [SAMPLE_W-1:0] cal_millivolts;
      logic [RATIO_W-1:0]  divider_ratio;
   } csr_cfg_type;

   // Data handed from one sort cell to the next
   typedef struct packed {
      logic                held_valid;
      logic [SAMPLE_W-1:0] held_data;
      logic                pass_valid;
      logic [SAMPLE_W-1:0] pass_data;
   } sort_link_type;

   // Row-wide control of the sort cells
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage

// File: rtl/tmav_if.sv
// Request and response channel interfaces of the trimmed-mean ADC filter.
interface tmav_req_if;
   import tmav_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface tmav_rsp_if;
   import tmav_pkg::*;

   logic                valid;
   logic                ready;
   logic [MV_W-1:0]     battery_mv;
   logic [SAMPLE_W-1:0] trimmed_average;

   modport source (output valid, output battery_mv, output trimmed_average, input ready);
   modport sink   (input valid, input battery_mv, input trimmed_average, output ready);
endinterface

// File: rtl/trimmed_mean_adc_to_millivolts.sv
// Trimmed-mean ADC filter: each burst is one warm-up sample followed by BURST_SAMPLES
// samples; the warm-up is dropped, the rest are insertion-sorted on the fly by a row of
// BURST_SAMPLES compare-and-exchange cells, the TRIM_EACH_END lowest and highest are
// discarded, and the truncated mean of the middle is scaled to millivolts and multiplied
// by the divider ratio, giving one response per burst. Samples are taken one per cycle
// while a burst is collected and the request side is not stalled. After the last sample
// of a burst the block is busy: the sort row settles, the row is shifted out into the
// accumulator, the mean is formed by reciprocal multiplication, the calibration product
// is formed, one 24-step pass of the restoring divider does the calibration scaling, and
// the result is handed on. A finished response waits in an output register, so the next
// burst is collected while it is pending; the request side stalls whenever a finished
// result waits to be loaded into that register, which happens once the register is free.
module trimmed_mean_adc_to_millivolts #(
   parameter int BURST_SAMPLES = 16,
   parameter int TRIM_EACH_END = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   tmav_req_if.sink                      req_ch,
   tmav_rsp_if.source                    rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tmav_pkg::ADDR_W-1:0]   paddr,
   input  logic [tmav_pkg::DATA_W-1:0]   pwdata,
   output logic [tmav_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import tmav_pkg::*;

`include "trimmed_mean_adc_to_millivolts_defines.svh"

   localparam int MID_COUNT = (2 * TRIM_EACH_END < BURST_SAMPLES) ?
                              BURST_SAMPLES - 2 * TRIM_EACH_END : 0;
   localparam int POS_W     = $clog2(BURST_SAMPLES + 1);
   localparam int CNT_W     = $clog2(BURST_SAMPLES);
   localparam int SUM_W     = SAMPLE_W + $clog2(BURST_SAMPLES);

   // Mean by reciprocal: floor(sum / MID_COUNT) = (sum * RECIP) >> SHIFT for any sum
   localparam int MID_DIV    = (MID_COUNT > 0) ? MID_COUNT : 1;
   localparam int MEAN_SHIFT = SUM_W + $clog2(MID_DIV);
   localparam int RECIP_W    = SUM_W + 2;
   localparam int PROD_W     = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << MEAN_SHIFT) + 64'(MID_DIV) - 64'd1) / 64'(MID_DIV);
   localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(RECIP_FULL);

   typedef enum logic [6:0] {
      ST_COLLECT    = 7'b000_0001,
      ST_SETTLE     = 7'b000_0010,
      ST_DRAIN      = 7'b000_0100,
      ST_AVG        = 7'b000_1000,
      ST_MUL        = 7'b001_0000,
      ST_SCALE      = 7'b010_0000,
      ST_SCALE_WAIT = 7'b100_0000
   } state_type;

   // A response is loaded in ST_SCALE_WAIT's successor; reuse ST_COLLECT after loading
   logic                out_pend_ff, out_pend_in;

   state_type           state_ff, state_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [DIV_W-1:0]    prod_ff, prod_in;
   logic [DIV_W-1:0]    pin_ff, pin_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]     rsp_mv_ff, rsp_mv_in;
   logic [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;

   csr_cfg_type         cfg;
   cell_ctrl_type       cell_ctrl;
   sort_link_type       links [BURST_SAMPLES+1];
   logic [BURST_SAMPLES-1:0] pass_valid_vec;
   logic [BURST_SAMPLES-1:0] held_valid_vec;

   logic                accept;
   logic                insert;
   logic                keep;
   logic                cnt_last;
   logic                cal_ok;
   logic [PROD_W-1:0]   mean_prod;
   logic                div_start;
   logic                div_done;
   logic [DIV_W-1:0]    div_dividend;
   logic [SAMPLE_W-1:0] div_divisor;
   logic [DIV_W-1:0]    div_quotient;

   // Configuration registers
   tmav_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Request handshake
   assign req_ch.ready = (state_ff == ST_COLLECT) && !out_pend_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign insert       = accept && (pos_ff != '0);

   // Sort row: new samples enter at cell 0
   assign links[0].held_valid = 1'b0;
   assign links[0].held_data  = '0;
   assign links[0].pass_valid = insert;
   assign links[0].pass_data  = req_ch.sample;

   assign cell_ctrl.clear = accept && (pos_ff == '0);
   assign cell_ctrl.shift = (state_ff == ST_DRAIN);

   for (genvar i = 0; i < BURST_SAMPLES; i++) begin : g_cell
      tmav_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (cell_ctrl),
         .left  (links[i]),
         .right (links[i+1])
      );
      assign pass_valid_vec[i] = links[i+1].pass_valid;
      assign held_valid_vec[i] = links[i+1].held_valid;
   end

   // Drain step k reads sorted rank BURST_SAMPLES-1-k; keep the middle ranks
   assign keep     = (int'(cnt_ff) >= TRIM_EACH_END) &&
                     (int'(cnt_ff) < BURST_SAMPLES - TRIM_EACH_END);
   assign cnt_last = (cnt_ff == CNT_W'(BURST_SAMPLES - 1));
   assign cal_ok   = (cfg.cal_code != '0);

   // Mean of the kept samples, constant reciprocal
   assign mean_prod = PROD_W'(sum_ff) * PROD_W'(MEAN_RECIP);

   // Divider for the calibration scaling
   assign div_start    = (state_ff == ST_SCALE);
   assign div_dividend = prod_ff;
   assign div_divisor  = cal_ok ? cfg.cal_code : FALLBACK_CODE;

   tmav_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      prod_in      = prod_ff;
      pin_in       = pin_ff;
      out_pend_in  = out_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_mv_in    = rsp_mv_ff;
      rsp_avg_in   = rsp_avg_ff;

      case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (pos_ff == POS_W'(BURST_SAMPLES)) begin
                  pos_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_SETTLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_SETTLE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               sum_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (keep) begin
               sum_in = sum_ff + SUM_W'(links[BURST_SAMPLES].held_data);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            if (MID_COUNT == 0) begin
               avg_in = '0;
            end else begin
               avg_in = SAMPLE_W'(mean_prod >> MEAN_SHIFT);
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = DIV_W'(avg_ff) * DIV_W'(cal_ok ? cfg.cal_millivolts : FALLBACK_MV);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_SCALE_WAIT;
         end
         ST_SCALE_WAIT: begin
            if (div_done) begin
               pin_in      = div_quotient;
               out_pend_in = 1'b1;
               state_in    = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase

      // Load the response register once it is free
      if (out_pend_ff && !rsp_valid_ff) begin
         out_pend_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_mv_in    = MV_W'(pin_ff) * MV_W'(cfg.divider_ratio);
         rsp_avg_in   = avg_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         out_pend_ff  <= out_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      avg_ff     <= avg_in;
      prod_ff    <= prod_in;
      pin_ff     <= pin_in;
      rsp_mv_ff  <= rsp_mv_in;
      rsp_avg_ff <= rsp_avg_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.battery_mv      = rsp_mv_ff;
   assign rsp_ch.trimmed_average = rsp_avg_ff;

   // Sort row has settled before it is shifted out
   `TMAV_ASSERT_NOW(a_row_settled, clock, reset, state_ff == ST_DRAIN,
      pass_valid_vec == '0, "sort row still moving during drain")

   // Every cell holds a sample when the drain starts
   `TMAV_ASSERT_NOW(a_row_full, clock, reset, state_ff == ST_DRAIN && cnt_ff == '0,
      held_valid_vec == '1, "sort row not full at drain start")

   // Last sample of a burst starts processing
   `TMAV_ASSERT_NEXT(a_burst_end, clock, reset,
      accept && pos_ff == POS_W'(BURST_SAMPLES), state_ff == ST_SETTLE,
      "burst end did not start processing")

   // Divider finishes only while a result is awaited
   `TMAV_ASSERT_NOW(a_div_done, clock, reset, div_done,
      state_ff == ST_SCALE_WAIT,
      "divider done outside the wait state")

endmodule

// File: rtl/tmav_cell.sv
// One cell of the insertion-sort row: keeps the smaller value, passes the larger on.
module tmav_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  tmav_pkg::cell_ctrl_type ctrl,
   input  tmav_pkg::sort_link_type left,
   output tmav_pkg::sort_link_type right
);
   import tmav_pkg::*;

   logic                held_valid_ff, held_valid_in;
   logic [SAMPLE_W-1:0] held_data_ff, held_data_in;
   logic                pass_valid_ff, pass_valid_in;
   logic [SAMPLE_W-1:0] pass_data_ff, pass_data_in;

   // Compare-and-exchange, or shift toward the row end while draining
   always_comb begin
      held_valid_in = held_valid_ff;
      held_data_in  = held_data_ff;
      pass_valid_in = 1'b0;
      pass_data_in  = pass_data_ff;
      if (ctrl.clear) begin
         held_valid_in = 1'b0;
      end else if (ctrl.shift) begin
         held_data_in = left.held_data;
      end else if (left.pass_valid) begin
         if (!held_valid_ff) begin
            held_valid_in = 1'b1;
            held_data_in  = left.pass_data;
         end else if (left.pass_data < held_data_ff) begin
            held_data_in  = left.pass_data;
            pass_valid_in = 1'b1;
            pass_data_in  = held_data_ff;
         end else begin
            pass_valid_in = 1'b1;
            pass_data_in  = left.pass_data;
         end
      end
   end

   // Control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         pass_valid_ff <= pass_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      held_data_ff <= held_data_in;
      pass_data_ff <= pass_data_in;
   end

   assign right.held_valid = held_valid_ff;
   assign right.held_data  = held_data_ff;
   assign right.pass_valid = pass_valid_ff;
   assign right.pass_data  = pass_data_ff;

endmodule

// File: rtl/tmav_divider.sv
// Restoring divider, one quotient bit per cycle.
module tmav_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tmav_pkg::DIV_W-1:0]      dividend,
   input  logic [tmav_pkg::SAMPLE_W-1:0]   divisor,
   output logic                            done,
   output logic [tmav_pkg::DIV_W-1:0]      quotient
);
   import tmav_pkg::*;

   localparam int STEP_W = $clog2(DIV_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SAMPLE_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [SAMPLE_W-1:0] dvs_ff, dvs_in;
   logic [SAMPLE_W:0]   trial;
   logic                fits;

   // Shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? SAMPLE_W'(trial - {1'b0, dvs_ff}) : trial[SAMPLE_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/tmav_csr.sv
// APB-style configuration registers: calibration code, calibration mV, divider ratio.
module tmav_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tmav_pkg::ADDR_W-1:0]   paddr,
   input  logic [tmav_pkg::DATA_W-1:0]   pwdata,
   output logic [tmav_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output tmav_pkg::csr_cfg_type         cfg
);
   import tmav_pkg::*;

   csr_cfg_type   cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index = reg_index_type'(paddr[3:2]);
   assign wr_en = psel && penable && pwrite;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_CAL_CODE:  cfg_in.cal_code       = pwdata[SAMPLE_W-1:0];
            REG_CAL_MV:    cfg_in.cal_millivolts = pwdata[SAMPLE_W-1:0];
            REG_DIV_RATIO: cfg_in.divider_ratio  = pwdata[RATIO_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cal_code       <= CAL_CODE_RESET;
         cfg_ff.cal_millivolts <= CAL_MV_RESET;
         cfg_ff.divider_ratio  <= RATIO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back
   always_comb begin
      case (index)
         REG_CAL_CODE:  prdata = DATA_W'(cfg_ff.cal_code);
         REG_CAL_MV:    prdata = DATA_W'(cfg_ff.cal_millivolts);
         REG_DIV_RATIO: prdata = DATA_W'(cfg_ff.divider_ratio);
         default:       prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the trimmed-mean ADC filter: sample bursts, register setups, checks.
module tb;
   import tmav_pkg::*;

   localparam int BURST_LEN     = 16;
   localparam int TRIM_EACH     = 4;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 600;
   localparam longint WATCHDOG_CYCLES = 300000;

   typedef struct packed {
      logic [MV_W-1:0]     battery_mv;
      logic [SAMPLE_W-1:0] trimmed_average;
   } reading_type;

   typedef enum int {
      FILL_UNIFORM,
      FILL_CLUSTER,
      FILL_EXTREMES,
      FILL_CONSTANT
   } fill_kind_type;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [ADDR_W-1:0]   paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   tmav_req_if req_ch();
   tmav_rsp_if rsp_ch();

   trimmed_mean_adc_to_millivolts #(
      .BURST_SAMPLES(BURST_LEN),
      .TRIM_EACH_END(TRIM_EACH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Mirror of the filter: registers, burst position and stored samples
   logic [SAMPLE_W-1:0] cal_code_q = CAL_CODE_RESET;
   logic [SAMPLE_W-1:0] cal_mv_q   = CAL_MV_RESET;
   logic [RATIO_W-1:0]  ratio_q    = RATIO_RESET;
   int                  burst_pos  = 0;
   logic [SAMPLE_W-1:0] burst_store [BURST_LEN];

   reading_type pending_readings[$];
   int          mismatch_count = 0;

   // Idle knobs
   int sender_max_gap     = 0;
   int receiver_max_stall = 0;
   int long_hold          = 0;

   always #6 clock = ~clock;

   // Mismatch report: the first ten are printed, the rest only counted
   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %0s: expected %0d, got %0d at %0t", what, want, got, $realtime);
   endtask

   // Fold one accepted sample into the mirror; the last of a burst yields a reading
   function automatic void take_sample(logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] sorted [BURST_LEN];
      logic [SAMPLE_W-1:0] key;
      longint unsigned     sum;
      longint unsigned     avg;
      longint unsigned     pin_mv;
      int                  j;
      reading_type         r;
      if (burst_pos == 0) begin
         // warm-up sample is dropped
         burst_pos = 1;
         return;
      end
      burst_store[burst_pos - 1] = s;
      if (burst_pos < BURST_LEN) begin
         burst_pos++;
         return;
      end
      burst_pos = 0;

      // ascending insertion sort of the burst
      sorted = burst_store;
      for (int i = 1; i < BURST_LEN; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j - 1] > key) begin
            sorted[j] = sorted[j - 1];
            j--;
         end
         sorted[j] = key;
      end

      // truncated mean of the middle samples
      sum = 64'd0;
      for (int i = TRIM_EACH; i + TRIM_EACH < BURST_LEN; i++)
         sum += 64'(sorted[i]);
      avg = (BURST_LEN > 2 * TRIM_EACH) ? sum / 64'(BURST_LEN - 2 * TRIM_EACH) : 64'd0;

      // calibration scaling, fallback when no calibration point
      if (cal_code_q != 0)
         pin_mv = (avg * 64'(cal_mv_q)) / 64'(cal_code_q);
      else
         pin_mv = (avg * 64'(FALLBACK_MV)) / 64'(FALLBACK_CODE);

      r.battery_mv      = MV_W'(pin_mv * 64'(ratio_q));
      r.trimmed_average = SAMPLE_W'(avg);
      pending_readings.push_back(r);
   endfunction

   // Request monitor feeds the mirror
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         take_sample(req_ch.sample);
   end

   // Response checker against the oldest expected reading
   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected response battery_mv", 64'd0,
                            64'(rsp_ch.battery_mv));
         end else begin
            want = pending_readings.pop_front();
            if (rsp_ch.battery_mv !== want.battery_mv)
               report_mismatch("battery_mv", 64'(want.battery_mv),
                               64'(rsp_ch.battery_mv));
            if (rsp_ch.trimmed_average !== want.trimmed_average)
               report_mismatch("trimmed_average", 64'(want.trimmed_average),
                               64'(rsp_ch.trimmed_average));
         end
      end
   end

   // Response side: random stall per reading, plus an optional long hold-off
   initial begin : response_side
      int n;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (long_hold > 0) begin
            n = long_hold;
            long_hold = 0;
         end else begin
            n = $urandom_range(0, receiver_max_stall);
         end
         if (n > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
         @(negedge clock);
      end
   end

   // Send one sample request; valid stays up so back-to-back requests need no gap
   task automatic send_sample(logic [SAMPLE_W-1:0] s);
      int gap;
      gap = $urandom_range(0, sender_max_gap);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.sample = s;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [SAMPLE_W-1:0] draw_sample(fill_kind_type kind,
                                                      logic [SAMPLE_W-1:0] center);
      int v;
      case (kind)
         FILL_CLUSTER: begin
            // tight spread around a center with occasional outliers
            v = int'(center) + int'($urandom_range(0, 64)) - 32;
            if ($urandom_range(0, 3) == 0)
               v = int'($urandom_range(0, 4095));
            if (v < 0)
               v = 0;
            if (v > 4095)
               v = 4095;
         end
         FILL_EXTREMES: begin
            case ($urandom_range(0, 2))
               0:       v = 0;
               1:       v = 4095;
               default: v = int'($urandom_range(0, 4095));
            endcase
         end
         FILL_CONSTANT: v = int'(center);
         default:       v = int'($urandom_range(0, 4095));
      endcase
      return v[SAMPLE_W-1:0];
   endfunction

   // Warm-up plus a full burst
   task automatic send_burst(fill_kind_type kind, logic [SAMPLE_W-1:0] center);
      for (int k = 0; k <= BURST_LEN; k++)
         send_sample(draw_sample(kind, center));
   endtask

   // Stop requesting, wait for every reading, then let the block go idle
   task automatic wait_for_readings();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register read, compared with the mirror at the register's width
   task automatic csr_check_readback(reg_index_type idx);
      logic [DATA_W-1:0] want;
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] got;
      case (idx)
         REG_CAL_CODE: begin
            want = DATA_W'(cal_code_q);
            mask = DATA_W'({SAMPLE_W{1'b1}});
         end
         REG_CAL_MV: begin
            want = DATA_W'(cal_mv_q);
            mask = DATA_W'({SAMPLE_W{1'b1}});
         end
         default: begin
            want = DATA_W'(ratio_q);
            mask = DATA_W'({RATIO_W{1'b1}});
         end
      endcase
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = {idx, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if ((got & mask) !== want)
         report_mismatch($sformatf("register %0s readback", idx.name()), 64'(want),
                         64'(got & mask));
   endtask

   // Register write through the setup and access phases, then read back
   task automatic csr_program(reg_index_type idx, logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_CAL_CODE: cal_code_q = value[SAMPLE_W-1:0];
         REG_CAL_MV:   cal_mv_q   = value[SAMPLE_W-1:0];
         default:      ratio_q    = value[RATIO_W-1:0];
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      csr_check_readback(idx);
   endtask

   task automatic csr_program_all(logic [SAMPLE_W-1:0] code, logic [SAMPLE_W-1:0] mv,
                                  logic [RATIO_W-1:0] ratio);
      csr_program(REG_CAL_CODE, DATA_W'(code));
      csr_program(REG_CAL_MV, DATA_W'(mv));
      csr_program(REG_DIV_RATIO, DATA_W'(ratio));
   endtask

   // Registers come out of reset with their documented values
   task automatic test_register_reset();
      csr_check_readback(REG_CAL_CODE);
      csr_check_readback(REG_CAL_MV);
      csr_check_readback(REG_DIV_RATIO);
   endtask

   // Hand-made burst at reset settings: high warm-up, outliers at both ends,
   // and middle values that toggle every sample bit
   task automatic test_warmup_and_trim();
      logic [SAMPLE_W-1:0] burst [BURST_LEN + 1];
      burst = '{12'hFFF,
                12'h000, 12'hFFF, 12'h800, 12'h000, 12'h7FF, 12'hFFF, 12'h000, 12'h555,
                12'hAAA, 12'hFFF, 12'h000, 12'h001, 12'hFFE, 12'hFFF, 12'h0F0, 12'hF0F};
      sender_max_gap     = 0;
      receiver_max_stall = 0;
      foreach (burst[k])
         send_sample(burst[k]);
      wait_for_readings();
   endtask

   // Registers rewritten in the middle of a burst: values at the last sample apply
   task automatic test_register_change_mid_burst();
      sender_max_gap     = 3;
      receiver_max_stall = 3;
      csr_program_all(12'd2000, 12'd1000, 4'd3);
      for (int k = 0; k <= BURST_LEN / 2; k++)
         send_sample(SAMPLE_W'($urandom_range(0, 4095)));
      wait_for_readings();
      csr_program(REG_DIV_RATIO, 32'd9);
      csr_program(REG_CAL_MV, 32'd3300);
      for (int k = BURST_LEN / 2 + 1; k <= BURST_LEN; k++)
         send_sample(SAMPLE_W'($urandom_range(0, 4095)));
      wait_for_readings();
   endtask

   // Random bursts over a range of calibration settings, extremes included
   task automatic test_calibration_sweep();
      logic [SAMPLE_W-1:0] code;
      logic [SAMPLE_W-1:0] mv;
      logic [RATIO_W-1:0]  ratio;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin code = 12'd4095; mv = 12'd4095; ratio = 4'd15; end
            1: begin code = 12'd1;    mv = 12'd4095; ratio = 4'd15; end
            2: begin code = 12'd4095; mv = 12'd0;    ratio = 4'd1;  end
            3: begin code = 12'd0;    mv = 12'd850;  ratio = 4'd0;  end  // fallback, zero divider
            4: begin code = 12'd0;    mv = 12'd4095; ratio = 4'd15; end  // fallback
            5: begin
               code  = SAMPLE_W'($urandom_range(1, 4095));
               mv    = SAMPLE_W'($urandom_range(0, 4095));
               ratio = RATIO_W'($urandom_range(1, 15));
            end
            default: begin
               code  = SAMPLE_W'($urandom_range(0, 4095));
               mv    = SAMPLE_W'($urandom_range(0, 4095));
               ratio = RATIO_W'($urandom_range(0, 15));
            end
         endcase
         csr_program_all(code, mv, ratio);
         sender_max_gap     = (phase % 3 == 0) ? 0 : 15;
         receiver_max_stall = (phase % 2 == 0) ? 15 : 0;
         for (int b = 0; b < 3; b++) begin
            // full-scale burst at the largest gain gives the largest battery_mv
            if (phase == 1 && b == 0)
               send_burst(FILL_CONSTANT, 12'hFFF);
            else
               send_burst(fill_kind_type'($urandom_range(0, 3)),
                          SAMPLE_W'($urandom_range(0, 4095)));
         end
         wait_for_readings();
      end
   endtask

   // Response side holds off long enough that the pending reading, the next
   // burst and then the request side all back up
   task automatic test_output_backpressure();
      sender_max_gap     = 0;
      receiver_max_stall = 0;
      long_hold          = HOLD_CYCLES;
      for (int b = 0; b < 4; b++)
         send_burst(fill_kind_type'($urandom_range(0, 3)),
                    SAMPLE_W'($urandom_range(0, 4095)));
      wait_for_readings();
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_reset();
      test_warmup_and_trim();
      test_register_change_mid_burst();
      test_calibration_sweep();
      test_output_backpressure();

      if (mismatch_count == 0 && pending_readings.size() == 0)
         $display("[trimmed_mean_adc_to_millivolts] OK");
      else
         $display("[trimmed_mean_adc_to_millivolts] ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #(WATCHDOG_CYCLES * 12);
      $display("[trimmed_mean_adc_to_millivolts] ERROR");
      $finish;
   end

endmodule
